[sv/rcds_pkg.sv]
// Shared types, constants and helper functions for the domain selection block.
package rcds_pkg;

  localparam int ATOM_W      = 5;
  localparam int MAG_W       = 18;
  localparam int CONTRIB_W   = 37;
  localparam int SUM_W       = 48;
  localparam int DOM_W       = 32;
  localparam int CNT_W       = 6;
  localparam int CUT_W       = 16;
  localparam int THR_W       = SUM_W + CUT_W;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 1'd1;

  // One classified basis-function item on its way to the accumulator.
  typedef struct packed {
    logic [ATOM_W-1:0]    atom;
    logic                 add_en;
    logic [CONTRIB_W-1:0] contrib;
    logic [DOM_W-1:0]     existing;
    logic                 last;
  } q_entry_t;

  function automatic logic [MAG_W-1:0] mag18(input logic [MAG_W-1:0] raw);
    logic [MAG_W-1:0] neg;
    neg = (~raw) + MAG_W'(1);
    return raw[MAG_W-1] ? neg : raw;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

[sv/rcds_front.sv]
// Front end: takes input transfers, checks the atom range and forms 4*|z*mu|.
module rcds_front import rcds_pkg::*; (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic                 in_last_i,
  input  logic [CNT_W-1:0]     eff_count_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output q_entry_t             entry_o
);

  logic [ATOM_W-1:0]  atom;
  logic [MAG_W-1:0]   resp_raw;
  logic [MAG_W-1:0]   dip_raw;
  logic [2*MAG_W-1:0] prod;

  assign atom     = in_data_i[ATOM_W-1:0];
  assign resp_raw = in_data_i[ATOM_W +: MAG_W];
  assign dip_raw  = in_data_i[ATOM_W+MAG_W +: MAG_W];
  assign prod     = mag18(resp_raw) * mag18(dip_raw);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    entry_o.atom     = atom;
    // Items for atoms beyond the active count still carry their last mark.
    entry_o.add_en   = {1'b0, atom} < eff_count_i;
    entry_o.contrib  = CONTRIB_W'({prod, 2'b00});
    entry_o.existing = in_data_i[ATOM_W+2*MAG_W +: DOM_W];
    entry_o.last     = in_last_i;
  end

endmodule

[sv/rcds_queue.sv]
// Short FIFO between the front end and the accumulate/rank back end.
module rcds_queue import rcds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     empty_o,
  output q_entry_t head_o
);

  q_entry_t            store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;

  assign full_o  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[sv/rcds_back.sv]
// Back end: per-atom accumulation, ranking walk, cutoff test and result register.
module rcds_back import rcds_pkg::*; #(
  parameter int MAX_ATOMS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CNT_W-1:0]      eff_count_i,
  input  logic [CUT_W-1:0]      cutoff_i,
  input  q_entry_t              head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int NA     = (MAX_ATOMS > 32) ? 32 : MAX_ATOMS;
  localparam int AW     = $clog2(NA);
  localparam int CW     = $clog2(NA + 1);
  localparam int HALF_W = SUM_W / 2;
  localparam int PROD_W = HALF_W + CUT_W;

  typedef enum logic [7:0] {
    ST_FETCH = 8'b0000_0001,
    ST_ADD   = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_THR   = 8'b0000_1000,
    ST_SCAN  = 8'b0001_0000,
    ST_SUM   = 8'b0010_0000,
    ST_REM   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [SUM_W-1:0] sums_mem [NA];
  logic [SUM_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [SUM_W-1:0] wr_data;

  logic [NA-1:0]    vld_q, vld_d;
  logic [NA-1:0]    used_q, used_d;
  q_entry_t         cur_q, cur_d;
  logic [SUM_W-1:0] total_q, total_d;
  logic [PROD_W-1:0] prod_lo_q, prod_lo_d;
  logic [PROD_W-1:0] prod_hi_q, prod_hi_d;
  logic [THR_W-1:0] thr_q, thr_d;
  logic [CW-1:0]    rank_q, rank_d;
  logic [SUM_W-1:0] running_q, running_d;
  logic [CNT_W-1:0] added_q, added_d;
  logic             fresh_q, fresh_d;
  logic [AW-1:0]    best_k_q, best_k_d;
  logic [SUM_W-1:0] best_val_q, best_val_d;
  logic             have_q, have_d;
  logic [AW-1:0]    scan_k_q, scan_k_d;
  logic             issue_q, issue_d;
  logic [AW-1:0]    cmp_k_q, cmp_k_d;
  logic             cmp_v_q, cmp_v_d;
  logic [SUM_W-1:0] rem_q, rem_d;
  logic             out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic             out_last_q, out_last_d;

  logic [CW-1:0]    n_cw;
  logic [CW-1:0]    n_m1;
  logic [SUM_W-1:0] rd_val;
  logic             cmp_take;
  logic             emit_done;
  logic             emit_last;
  logic             out_free;

  assign n_cw      = CW'(eff_count_i);
  assign n_m1      = n_cw - CW'(1);
  // An entry not written since the last clear reads as zero.
  assign rd_val    = rd_vld_q ? rd_data_q : '0;
  // Ascending scan with >= hands ties to the higher atom index.
  assign cmp_take  = cmp_v_q && !used_q[cmp_k_q] && (!have_q || rd_val >= best_val_q);
  assign emit_done = (total_q != '0) && ({rem_q, {CUT_W{1'b0}}} <= thr_q);
  assign emit_last = emit_done || (rank_q == n_m1);
  assign out_free  = !out_valid_q || m_axis_tready;

  assign rd_addr = (state_q == ST_FETCH) ? AW'(head_i.atom) : scan_k_q;
  assign wr_addr = AW'(cur_q.atom);
  assign wr_data = sat_add(rd_val, SUM_W'(cur_q.contrib));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    vld_d       = vld_q;
    used_d      = used_q;
    total_d     = total_q;
    prod_lo_d   = prod_lo_q;
    prod_hi_d   = prod_hi_q;
    thr_d       = thr_q;
    rank_d      = rank_q;
    running_d   = running_q;
    added_d     = added_q;
    fresh_d     = fresh_q;
    best_k_d    = best_k_q;
    best_val_d  = best_val_q;
    have_d      = have_q;
    scan_k_d    = scan_k_q;
    issue_d     = issue_q;
    cmp_k_d     = cmp_k_q;
    cmp_v_d     = 1'b0;
    rem_d       = rem_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    pop_o       = 1'b0;
    wr_en       = 1'b0;

    unique case (state_q)
      ST_FETCH: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cur_d   = head_i;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (cur_q.add_en) begin
          wr_en          = 1'b1;
          vld_d[wr_addr] = 1'b1;
          total_d        = sat_add(total_q, SUM_W'(cur_q.contrib));
        end
        state_d = cur_q.last ? ST_MUL : ST_FETCH;
      end
      ST_MUL: begin
        // Split cutoff * total into two narrow partial products.
        prod_lo_d = total_q[HALF_W-1:0] * cutoff_i;
        prod_hi_d = total_q[SUM_W-1:HALF_W] * cutoff_i;
        state_d   = ST_THR;
      end
      ST_THR: begin
        thr_d     = {prod_hi_q, {HALF_W{1'b0}}} + THR_W'(prod_lo_q);
        rank_d    = '0;
        used_d    = '0;
        running_d = '0;
        added_d   = '0;
        scan_k_d  = '0;
        issue_d   = 1'b1;
        have_d    = 1'b0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue_q) begin
          scan_k_d = scan_k_q + AW'(1);
          if (CW'(scan_k_q) == n_m1) begin
            issue_d = 1'b0;
          end
        end
        cmp_v_d = issue_q;
        cmp_k_d = scan_k_q;
        if (cmp_take) begin
          best_k_d   = cmp_k_q;
          best_val_d = rd_val;
          have_d     = 1'b1;
        end
        if (cmp_v_q && CW'(cmp_k_q) == n_m1) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        running_d        = sat_add(running_q, best_val_q);
        used_d[best_k_q] = 1'b1;
        fresh_d          = !cur_q.existing[ATOM_W'(best_k_q)];
        if (!cur_q.existing[ATOM_W'(best_k_q)]) begin
          added_d = added_q + CNT_W'(1);
        end
        state_d = ST_REM;
      end
      ST_REM: begin
        // Running may pass the total after saturation: take the magnitude.
        rem_d   = (total_q >= running_q) ? total_q - running_q : running_q - total_q;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_DATA_W'({added_q, fresh_q, ATOM_W'(best_k_q)});
          out_last_d  = emit_last;
          if (emit_last) begin
            vld_d   = '0;
            total_d = '0;
            state_d = ST_FETCH;
          end else begin
            rank_d   = rank_q + CW'(1);
            scan_k_d = '0;
            issue_d  = 1'b1;
            have_d   = 1'b0;
            state_d  = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FETCH;
      vld_q       <= '0;
      total_q     <= '0;
      issue_q     <= 1'b0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      total_q     <= total_d;
      issue_q     <= issue_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    used_q     <= used_d;
    prod_lo_q  <= prod_lo_d;
    prod_hi_q  <= prod_hi_d;
    thr_q      <= thr_d;
    rank_q     <= rank_d;
    running_q  <= running_d;
    added_q    <= added_d;
    fresh_q    <= fresh_d;
    best_k_q   <= best_k_d;
    best_val_q <= best_val_d;
    have_q     <= have_d;
    scan_k_q   <= scan_k_d;
    cmp_k_q    <= cmp_k_d;
    rem_q      <= rem_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // Per-atom sums: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sums_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= sums_mem[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
  end

`ifndef ASSERT_OFF
  a_best_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> !used_q[best_k_q])
    else $error("ranked atom already taken");

  a_rank_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> ($countones(used_q) == int'(rank_q)))
    else $error("ranking marks out of step with rank");

  a_scan_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cmp_v_q && CW'(cmp_k_q) == n_m1) |=> have_q)
    else $error("scan ended without a candidate");

  a_orbital_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && emit_last)
      |=> (state_q == ST_FETCH && vld_q == '0 && total_q == '0))
    else $error("orbital state not cleared after final result");
`endif

endmodule

[sv/ranked_contribution_domain_select.sv]
// Top level: configuration registers, front end, item queue and ranking back end.
// Accumulation: an accepted transfer reaches the back end through a 4-entry queue; the
//   back end reads the sum memory for each item, then adds and writes back.
// Selection after the last item: the cutoff threshold is formed from partial products,
//   then each emitted atom takes a scan over the sum memory, then sum, remainder, test.
// Reset clears control, sets atom_count to 32 and cutoff_fraction to 655; per-atom sums
//   read as zero through valid bits, so no clearing pass is needed.
module ranked_contribution_domain_select import rcds_pkg::*; #(
  parameter int MAX_ATOMS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // atom_index[4:0], response_value[22:5], dipole_value[40:23], existing_domain[72:41]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // selected_atom[4:0], newly_added[5], added_count[11:6]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CUT_W-1:0]      cfg_data_i
);

  localparam int NA_CAP = (MAX_ATOMS > 32) ? 32 : MAX_ATOMS;

  logic [CNT_W-1:0] atom_count_q;
  logic [CUT_W-1:0] cutoff_q;
  logic [CNT_W-1:0] eff_count;

  logic     q_full;
  logic     q_empty;
  logic     push;
  logic     pop;
  q_entry_t entry;
  q_entry_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_count_q <= CNT_W'(32);
      cutoff_q     <= CUT_W'(655);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATOM_COUNT: atom_count_q <= cfg_data_i[CNT_W-1:0];
        REG_CUTOFF:     cutoff_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp to the storage size; zero counts as one atom.
  always_comb begin
    if (atom_count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (atom_count_q > CNT_W'(NA_CAP)) begin
      eff_count = CNT_W'(NA_CAP);
    end else begin
      eff_count = atom_count_q;
    end
  end

  rcds_front u_front (
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .eff_count_i (eff_count),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (entry)
  );

  rcds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  rcds_back #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eff_count_i   (eff_count),
    .cutoff_i      (cutoff_q),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
